// ===== hw/rtl/afe_pkg.sv =====
// ----------------------------------------------------------------------------
// afe_pkg
// Shared constants and types for the audio front end with AGC and carrier
// detect.
// ----------------------------------------------------------------------------
package afe_pkg;

	localparam int AVG_DEPTH = 32;
	localparam int AVG_W     = $clog2(AVG_DEPTH);
	localparam int SUM_W     = 12 + AVG_W;
	localparam int MAX_BLOCK = 1024;
	localparam int MIN_BLOCK = 8;
	localparam int POS_W     = $clog2(MAX_BLOCK);
	localparam int LEN_W     = 11;
	localparam int GSUM_W    = 42;
	localparam int LSUM_W    = 35;
	localparam int LCNT_W    = 11;

	localparam logic [15:0] GAIN_RESET = 16'd4096;
	localparam logic [15:0] GAIN_MIN   = 16'd409;
	localparam logic [15:0] GAIN_MAX   = 16'd40960;

	localparam logic [1:0] CFG_BLOCK_LENGTH  = 2'd0;
	localparam logic [1:0] CFG_MV_SLOPE      = 2'd1;
	localparam logic [1:0] CFG_LEVEL_SUB     = 2'd2;
	localparam logic [1:0] CFG_FORCE_CARRIER = 2'd3;

	typedef struct packed {
		logic [10:0] block_length;
		logic [9:0]  mv_slope;
		logic [2:0]  level_subsample;
		logic        force_carrier;
	} afe_cfg_t;

	typedef struct packed {
		logic signed [16:0]  audio;
		logic                block_end;
		logic [15:0]         gain;
		logic [GSUM_W-1:0]   gsum;
		logic [LSUM_W-1:0]   lsum;
		logic [LCNT_W-1:0]   lcount;
		logic [LEN_W-1:0]    count;
	} afe_entry_t;

	typedef struct packed {
		logic        done;
		logic [15:0] gain;
	} afe_fb_t;

endpackage

// ===== hw/rtl/audio_front_end_agc_carrier_detect.sv =====
// ----------------------------------------------------------------------------
// audio_front_end_agc_carrier_detect
// Audio front end: DC removal, block RMS AGC and carrier detect.
// ----------------------------------------------------------------------------
// Each ADC sample passes through the steps accept, gain multiply, square and
// accumulate, and queue write; a new sample is accepted only once the previous
// one is written to the queue. The last sample of a block is followed by a wait
// while the block-end sequencer runs three 50-step divisions and two 25-step
// square roots on its shared bit-serial units (the level ones are skipped when
// no level samples were taken), plus the gain step multiplies; the next sample
// is taken once the updated gain is in place. A two-entry queue and an output
// register decouple the sample path from the result channel.
module audio_front_end_agc_carrier_detect import afe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [10:0]        cfg_data,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [11:0]        adc_sample,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [16:0] audio_sample,
	output logic               block_end,
	output logic               carrier_detect,
	output logic [11:0]        level_millivolts,
	output logic [15:0]        gain_q12
);

	afe_cfg_t   cfg_q;
	afe_fb_t    fb;
	afe_entry_t push_data, pop_data;
	logic       fifo_push, fifo_pop, fifo_full, fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_length    <= 11'd576;
			cfg_q.mv_slope        <= 10'd206;
			cfg_q.level_subsample <= 3'd4;
			cfg_q.force_carrier   <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_BLOCK_LENGTH:  cfg_q.block_length    <= cfg_data;
				CFG_MV_SLOPE:      cfg_q.mv_slope        <= cfg_data[9:0];
				CFG_LEVEL_SUB:     cfg_q.level_subsample <= cfg_data[2:0];
				CFG_FORCE_CARRIER: cfg_q.force_carrier   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	afe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.fb           (fb),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.adc_sample   (adc_sample),
		.push         (fifo_push),
		.entry        (push_data),
		.fifo_full    (fifo_full)
	);

	afe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.wdata  (push_data),
		.pop    (fifo_pop),
		.rdata  (pop_data),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	afe_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.force_carrier    (cfg_q.force_carrier),
		.fifo_empty       (fifo_empty),
		.fifo_data        (pop_data),
		.pop              (fifo_pop),
		.fb               (fb),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.audio_sample     (audio_sample),
		.block_end        (block_end),
		.carrier_detect   (carrier_detect),
		.level_millivolts (level_millivolts),
		.gain_q12         (gain_q12)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full)
		else $error("queue written while full");

	a_mid_block_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !block_end) |-> (!carrier_detect && level_millivolts == 12'd0))
		else $error("carrier or level reported off block end");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (gain_q12 >= GAIN_MIN && gain_q12 <= GAIN_MAX))
		else $error("gain out of range");

	a_forced_carrier: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && block_end && cfg_q.force_carrier && $stable(cfg_q.force_carrier))
		|-> carrier_detect)
		else $error("forced carrier not reported");

endmodule

// ===== hw/rtl/afe_front.sv =====
// ----------------------------------------------------------------------------
// afe_front
// Per-sample path: moving-average DC removal, gain multiply, block position
// tracking and accumulation of the gained and level square sums.
// ----------------------------------------------------------------------------
module afe_front import afe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  afe_cfg_t    cfg,
	input  afe_fb_t     fb,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [11:0] adc_sample,
	output logic        push,
	output afe_entry_t  entry,
	input  logic        fifo_full
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL  = 3'd1;
	localparam logic [2:0] F_SQ   = 3'd2;
	localparam logic [2:0] F_PUSH = 3'd3;
	localparam logic [2:0] F_WAIT = 3'd4;

	function automatic logic [11:0] to_mv(input logic [11:0] raw, input logic [9:0] slope);
		logic [21:0] p;
		p = 22'(raw) * 22'(slope);
		if (p[21:20] != 2'd0)
			return 12'hFFF;
		return p[19:8];
	endfunction

	logic [2:0]          state_q;
	logic [11:0]         ring_q [AVG_DEPTH];
	logic [AVG_W-1:0]    idx_q;
	logic [SUM_W-1:0]    sum_q;
	logic [POS_W-1:0]    pos_q;
	logic [2:0]          phase_q [2:7];
	logic [GSUM_W-1:0]   gsum_q;
	logic [LSUM_W-1:0]   lsum_q;
	logic [LCNT_W-1:0]   lcnt_q;
	logic [11:0]         dc_q;

	logic [11:0]         adc_s1;
	logic                take_s1, end_s1;
	logic [LEN_W-1:0]    n_s1;

	logic                neg_s2, take_s2, end_s2;
	logic [15:0]         mag_s2, gain_s2;
	logic [11:0]         mv_adc_s2, mv_avg_s2;
	logic [LEN_W-1:0]    n_s2;

	afe_entry_t          entry_q;

	logic                accept;
	logic [2:0]          sub;
	logic                take;
	logic [LEN_W-1:0]    len, pos_inc;
	logic                is_end;
	logic [11:0]         avg, absval;
	logic signed [12:0]  centred;
	logic [27:0]         prod;
	logic [31:0]         msq;
	logic signed [12:0]  dlev;
	logic signed [25:0]  dsq;

	assign accept       = sample_valid && (state_q == F_IDLE);
	assign sample_stall = (state_q != F_IDLE);
	assign push         = (state_q == F_PUSH) && !fifo_full;
	assign entry        = entry_q;

	always_comb begin
		sub = (cfg.level_subsample == 3'd0) ? 3'd1 : cfg.level_subsample;
		case (sub)
			3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7: take = (phase_q[sub] == 3'd0);
			default: take = 1'b1;
		endcase
		if (cfg.block_length < LEN_W'(MIN_BLOCK))
			len = LEN_W'(MIN_BLOCK);
		else if (cfg.block_length > LEN_W'(MAX_BLOCK))
			len = LEN_W'(MAX_BLOCK);
		else
			len = cfg.block_length;
		pos_inc = LEN_W'(pos_q) + LEN_W'(1);
		is_end  = (pos_inc >= len);
	end

	always_comb begin
		avg     = 12'(sum_q >> AVG_W);
		centred = $signed({1'b0, adc_s1}) - $signed({1'b0, avg});
		absval  = centred[12] ? 12'(-centred) : centred[11:0];
		prod    = 28'(absval) * 28'(fb.gain);
		msq     = 32'(mag_s2) * 32'(mag_s2);
		dlev    = $signed({1'b0, mv_adc_s2}) - $signed({1'b0, dc_q});
		dsq     = 26'(dlev) * 26'(dlev);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			idx_q   <= '0;
			sum_q   <= '0;
			pos_q   <= '0;
			gsum_q  <= '0;
			lsum_q  <= '0;
			lcnt_q  <= '0;
			dc_q    <= '0;
			for (int i = 0; i < AVG_DEPTH; i++)
				ring_q[i] <= '0;
			for (int k = 2; k <= 7; k++)
				phase_q[k] <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						sum_q         <= sum_q + SUM_W'(adc_sample) - SUM_W'(ring_q[idx_q]);
						ring_q[idx_q] <= adc_sample;
						idx_q         <= (idx_q == AVG_W'(AVG_DEPTH - 1)) ? '0 : idx_q + 1'b1;
						if (is_end) begin
							pos_q <= '0;
							for (int k = 2; k <= 7; k++)
								phase_q[k] <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
							for (int k = 2; k <= 7; k++)
								phase_q[k] <= (phase_q[k] == 3'(k - 1)) ? 3'd0 : phase_q[k] + 3'd1;
						end
						state_q <= F_MUL;
					end
				end
				F_MUL:  state_q <= F_SQ;
				F_SQ:   begin
					if (end_s2) begin
						gsum_q <= '0;
						lsum_q <= '0;
						lcnt_q <= '0;
						dc_q   <= mv_avg_s2;
					end else begin
						gsum_q <= gsum_q + GSUM_W'(msq);
						if (take_s2) begin
							lsum_q <= lsum_q + LSUM_W'($unsigned(dsq));
							lcnt_q <= lcnt_q + 1'b1;
						end
					end
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!fifo_full)
						state_q <= end_s2 ? F_WAIT : F_IDLE;
				end
				F_WAIT: begin
					// hold off the next sample until the new gain is in place
					if (fb.done)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			adc_s1  <= adc_sample;
			take_s1 <= take;
			end_s1  <= is_end;
			n_s1    <= pos_inc;
		end
		if (state_q == F_MUL) begin
			neg_s2    <= centred[12];
			mag_s2    <= prod[27:12];
			gain_s2   <= fb.gain;
			mv_adc_s2 <= to_mv(adc_s1, cfg.mv_slope);
			mv_avg_s2 <= to_mv(avg, cfg.mv_slope);
			take_s2   <= take_s1;
			end_s2    <= end_s1;
			n_s2      <= n_s1;
		end
		if (state_q == F_SQ) begin
			entry_q.audio     <= neg_s2 ? -$signed({1'b0, mag_s2}) : $signed({1'b0, mag_s2});
			entry_q.block_end <= end_s2;
			entry_q.gain      <= gain_s2;
			entry_q.gsum      <= gsum_q + GSUM_W'(msq);
			entry_q.lsum      <= take_s2 ? lsum_q + LSUM_W'($unsigned(dsq)) : lsum_q;
			entry_q.lcount    <= take_s2 ? lcnt_q + 1'b1 : lcnt_q;
			entry_q.count     <= n_s2;
		end
	end

endmodule

// ===== hw/rtl/afe_fifo.sv =====
// ----------------------------------------------------------------------------
// afe_fifo
// Two-entry queue between the sample path and the block-end unit.
// ----------------------------------------------------------------------------
module afe_fifo import afe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  afe_entry_t wdata,
	input  logic       pop,
	output afe_entry_t rdata,
	output logic       full,
	output logic       empty
);

	afe_entry_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule

// ===== hw/rtl/afe_back.sv =====
// ----------------------------------------------------------------------------
// afe_back
// Result stage and block-end sequencer: RMS, gain update, level measurement
// and carrier hysteresis on one shared bit-serial divider and square root.
// ----------------------------------------------------------------------------
module afe_back import afe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               force_carrier,
	input  logic               fifo_empty,
	input  afe_entry_t         fifo_data,
	output logic               pop,
	output afe_fb_t            fb,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [16:0] audio_sample,
	output logic               block_end,
	output logic               carrier_detect,
	output logic [11:0]        level_millivolts,
	output logic [15:0]        gain_q12
);

	localparam int DIV_N      = 50;
	localparam int DIV_D      = 32;
	localparam int SQ_STEPS   = DIV_N / 2;
	localparam int ERR_REF    = 209715;
	localparam logic [DIV_N-1:0] ERR_NUM = DIV_N'(ERR_REF) << 16;

	// step = x / 50 as (x >> 1) * ceil(2^26 / 25) >> 26,
	// step = x / 1000 as (x >> 3) * ceil(2^26 / 125) >> 26
	localparam logic [21:0] RECIP_50   = 22'd2684355;
	localparam logic [21:0] RECIP_1000 = 22'd536871;
	// any larger step already drives the gain past its upper clamp
	localparam logic [21:0] STEP_SAT   = 22'h3FFFFF;

	localparam logic [3:0] B_IDLE     = 4'd0;
	localparam logic [3:0] B_MS_DIV   = 4'd1;
	localparam logic [3:0] B_RMS_SQRT = 4'd2;
	localparam logic [3:0] B_ERR_DIV  = 4'd3;
	localparam logic [3:0] B_MUL_LO   = 4'd4;
	localparam logic [3:0] B_MUL_HI   = 4'd5;
	localparam logic [3:0] B_DIFF     = 4'd6;
	localparam logic [3:0] B_STEP     = 4'd7;
	localparam logic [3:0] B_GAIN     = 4'd8;
	localparam logic [3:0] B_LVL_DIV  = 4'd9;
	localparam logic [3:0] B_LVL_SQRT = 4'd10;
	localparam logic [3:0] B_COUNT    = 4'd11;
	localparam logic [3:0] B_DONE     = 4'd12;

	logic [3:0]          state_q;
	logic [15:0]         gain_q;
	logic [6:0]          counter_q;
	logic                out_valid_q;
	logic signed [16:0]  out_audio_q;
	logic                out_end_q, out_carrier_q;
	logic [11:0]         out_level_q;
	logic [15:0]         out_gain_q;

	logic signed [16:0]  audio_q;
	logic [15:0]         gain_used_q;
	logic [LSUM_W-1:0]   lsum_q;
	logic [LCNT_W-1:0]   lcnt_q;
	logic [30:0]         den_q;
	logic [33:0]         err_q;
	logic [32:0]         prod_lo_q;
	logic [33:0]         ge_q;
	logic                neg_q;
	logic [11:0]         level_q;
	logic [20:0]         step_x_q;
	logic [21:0]         step_m_q;
	logic [16:0]         step_q;

	logic [DIV_N-1:0]    div_num_q;
	logic [DIV_D-1:0]    div_den_q, div_rem_q;
	logic [5:0]          div_cnt_q;
	logic [DIV_N-1:0]    sq_val_q;
	logic [26:0]         sq_rem_q;
	logic [24:0]         sq_root_q;
	logic [4:0]          sq_cnt_q;

	logic                out_free;
	logic [DIV_D:0]      div_trial;
	logic                div_bit, div_last;
	logic [DIV_D-1:0]    div_rem_d;
	logic [DIV_N-1:0]    div_quo_d;
	logic [28:0]         sq_r2, sq_trial;
	logic                sq_bit, sq_last;
	logic [26:0]         sq_rem_d;
	logic [24:0]         sq_root_d;
	logic [49:0]         ge_full;
	logic [33:0]         abs_diff;
	logic [21:0]         step_sat;
	logic                slow;
	logic [42:0]         step_prod;
	logic [34:0]         gain_new;

	assign out_free = !out_valid_q || !result_stall;
	assign pop      = (state_q == B_IDLE) && !fifo_empty && (fifo_data.block_end || out_free);
	assign fb.done  = (state_q == B_DONE) && out_free;
	assign fb.gain  = gain_q;

	assign result_valid     = out_valid_q;
	assign audio_sample     = out_audio_q;
	assign block_end        = out_end_q;
	assign carrier_detect   = out_carrier_q;
	assign level_millivolts = out_level_q;
	assign gain_q12         = out_gain_q;

	always_comb begin
		div_trial = {div_rem_q, div_num_q[DIV_N-1]};
		div_bit   = (div_trial >= {1'b0, div_den_q});
		div_rem_d = div_bit ? DIV_D'(div_trial - {1'b0, div_den_q}) : div_trial[DIV_D-1:0];
		div_quo_d = {div_num_q[DIV_N-2:0], div_bit};
		div_last  = (div_cnt_q == 6'(DIV_N - 1));

		sq_r2     = {sq_rem_q, sq_val_q[DIV_N-1:DIV_N-2]};
		sq_trial  = {2'b00, sq_root_q, 2'b01};
		sq_bit    = (sq_r2 >= sq_trial);
		sq_rem_d  = sq_bit ? 27'(sq_r2 - sq_trial) : sq_r2[26:0];
		sq_root_d = {sq_root_q[23:0], sq_bit};
		sq_last   = (sq_cnt_q == 5'(SQ_STEPS - 1));

		ge_full   = 50'(prod_lo_q) + (50'(33'(gain_q) * 33'(err_q[33:17])) << 17);
		abs_diff  = (ge_q < 34'(gain_q)) ? 34'(gain_q) - ge_q : ge_q - 34'(gain_q);
		step_sat  = (abs_diff > 34'(STEP_SAT)) ? STEP_SAT : abs_diff[21:0];
		slow      = (den_q > 31'(ERR_REF));
		step_prod = 43'(step_x_q) * 43'(step_m_q);
		gain_new  = neg_q ? 35'(gain_q) - 35'(step_q)
		                  : 35'(gain_q) + 35'(step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			gain_q      <= GAIN_RESET;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && result_stall)
			            || (pop && !fifo_data.block_end)
			            || ((state_q == B_DONE) && out_free);
			unique case (state_q)
				B_IDLE: begin
					if (pop && fifo_data.block_end)
						state_q <= B_MS_DIV;
				end
				B_MS_DIV:   if (div_last) state_q <= B_RMS_SQRT;
				B_RMS_SQRT: if (sq_last) state_q <= B_ERR_DIV;
				B_ERR_DIV:  if (div_last) state_q <= B_MUL_LO;
				B_MUL_LO:   state_q <= B_MUL_HI;
				B_MUL_HI:   state_q <= B_DIFF;
				B_DIFF:     state_q <= B_STEP;
				B_STEP:     state_q <= B_GAIN;
				B_GAIN: begin
					if (gain_new > 35'(GAIN_MAX))
						gain_q <= GAIN_MAX;
					else if (gain_new < 35'(GAIN_MIN))
						gain_q <= GAIN_MIN;
					else
						gain_q <= gain_new[15:0];
					// an empty level sum leaves the counter alone
					state_q <= (lcnt_q == '0) ? B_DONE : B_LVL_DIV;
				end
				B_LVL_DIV:  if (div_last) state_q <= B_LVL_SQRT;
				B_LVL_SQRT: if (sq_last) state_q <= B_COUNT;
				B_COUNT: begin
					if (level_q > 12'd10) begin
						if (counter_q < 7'd100)
							counter_q <= counter_q + 7'd1;
					end else if (level_q < 12'd5) begin
						if (counter_q != 7'd0)
							counter_q <= counter_q - 7'd1;
					end
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (out_free)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_MS_DIV || state_q == B_ERR_DIV || state_q == B_LVL_DIV) begin
			div_num_q <= div_quo_d;
			div_rem_q <= div_rem_d;
			div_cnt_q <= div_cnt_q + 6'd1;
		end
		if (state_q == B_RMS_SQRT || state_q == B_LVL_SQRT) begin
			sq_val_q  <= sq_val_q << 2;
			sq_rem_q  <= sq_rem_d;
			sq_root_q <= sq_root_d;
			sq_cnt_q  <= sq_cnt_q + 5'd1;
		end

		case (state_q)
			B_IDLE: begin
				if (pop) begin
					if (fifo_data.block_end) begin
						audio_q     <= fifo_data.audio;
						gain_used_q <= fifo_data.gain;
						lsum_q      <= fifo_data.lsum;
						lcnt_q      <= fifo_data.lcount;
						div_num_q   <= {fifo_data.gsum, 8'd0};
						div_den_q   <= DIV_D'(fifo_data.count);
						div_rem_q   <= '0;
						div_cnt_q   <= '0;
					end else begin
						out_audio_q   <= fifo_data.audio;
						out_end_q     <= 1'b0;
						out_carrier_q <= 1'b0;
						out_level_q   <= '0;
						out_gain_q    <= fifo_data.gain;
					end
				end
			end
			B_MS_DIV, B_LVL_DIV: begin
				if (div_last) begin
					sq_val_q  <= div_quo_d;
					sq_rem_q  <= '0;
					sq_root_q <= '0;
					sq_cnt_q  <= '0;
				end
			end
			B_RMS_SQRT: begin
				if (sq_last) begin
					den_q     <= 31'({sq_root_d, 5'd0}) + 31'd1;
					div_num_q <= ERR_NUM;
					div_den_q <= DIV_D'({sq_root_d, 5'd0}) + DIV_D'(1);
					div_rem_q <= '0;
					div_cnt_q <= '0;
				end
			end
			B_ERR_DIV:  if (div_last) err_q <= div_quo_d[33:0];
			B_MUL_LO:   prod_lo_q <= 33'(gain_q) * 33'(err_q[16:0]);
			B_MUL_HI:   ge_q <= ge_full[49:16];
			B_DIFF: begin
				neg_q    <= (ge_q < 34'(gain_q));
				// slow step once the error is below one (gain falling), fast step otherwise
				step_x_q <= slow ? 21'(step_sat >> 3) : step_sat[21:1];
				step_m_q <= slow ? RECIP_1000 : RECIP_50;
			end
			B_STEP:     step_q <= step_prod[42:26];
			B_GAIN: begin
				level_q   <= '0;
				div_num_q <= DIV_N'(lsum_q);
				div_den_q <= DIV_D'(lcnt_q);
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			B_LVL_SQRT: if (sq_last) level_q <= sq_root_d[11:0];
			B_DONE: begin
				if (out_free) begin
					out_audio_q   <= audio_q;
					out_end_q     <= 1'b1;
					out_carrier_q <= (counter_q > 7'd3) || force_carrier;
					out_level_q   <= level_q;
					out_gain_q    <= gain_used_q;
				end
			end
			default: ;
		endcase
	end

endmodule
